FILE: sv/tlmsf_pkg.sv
// Package: shared types, constants and helpers of the manual set-up controller.
`timescale 1ns / 1ps
`default_nettype none
package tlmsf_pkg;

    localparam int DURATION_MAX = 99;
    localparam int TIMER_BITS   = 16;
    localparam int DUR_W        = 7;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_RED     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_AMBER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_GREEN   = 3'd4;

    localparam logic [TIMER_BITS-1:0] BLINK_HALF_RST   = 16'd50;
    localparam logic [TIMER_BITS-1:0] IDLE_TIMEOUT_RST = 16'd500;
    localparam logic [DUR_W-1:0]      INIT_RED_RST     = 7'd5;
    localparam logic [DUR_W-1:0]      INIT_AMBER_RST   = 7'd2;
    localparam logic [DUR_W-1:0]      INIT_GREEN_RST   = 7'd3;

    // Colour slots of the duration sets
    localparam int COL_RED   = 0;
    localparam int COL_AMBER = 1;
    localparam int COL_GREEN = 2;

    // Mode codes as seen on the result
    localparam logic [2:0] MODE_CODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_CODE_EXIT  = 3'd1;
    localparam logic [2:0] MODE_CODE_RED   = 3'd2;
    localparam logic [2:0] MODE_CODE_AMBER = 3'd3;
    localparam logic [2:0] MODE_CODE_GREEN = 3'd4;

    // Lamp drive codes
    localparam logic [2:0] LAMP_UNCHANGED = 3'd0;
    localparam logic [2:0] LAMP_RED       = 3'd1;
    localparam logic [2:0] LAMP_AMBER     = 3'd2;
    localparam logic [2:0] LAMP_GREEN     = 3'd3;
    localparam logic [2:0] LAMP_OFF       = 3'd4;

    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_EXIT  = 5'b00010,
        MODE_RED   = 5'b00100,
        MODE_AMBER = 5'b01000,
        MODE_GREEN = 5'b10000
    } mode_t;

    typedef struct packed {
        logic enter_manual;
        logic mode_short;
        logic mode_long;
        logic up_short;
        logic up_long;
        logic set_short;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       mode_now;
        logic [2:0]       lamp_drive;
        logic [DUR_W-1:0] shown_duration;
        logic [DUR_W-1:0] red_duration;
        logic [DUR_W-1:0] amber_duration;
        logic [DUR_W-1:0] green_duration;
        logic             return_to_auto;
    } result_t;

    // Timer control: tick advances the timer, load restarts it
    typedef struct packed {
        logic tick;
        logic load;
    } tmr_ctl_t;

    // Timer restart requests from the mode logic
    typedef struct packed {
        logic blink_load;
        logic idle_load;
    } tmr_load_t;

    // Raise a trial duration by one, wrapping past the top back to one
    function automatic logic [DUR_W-1:0] bump_duration(input logic [DUR_W-1:0] d);
        logic [DUR_W:0] v;
        v = {1'b0, d} + {{DUR_W{1'b0}}, 1'b1};
        if (v > (DUR_W+1)'(DURATION_MAX))
        begin
            v = (DUR_W+1)'(1);
        end
        return v[DUR_W-1:0];
    endfunction

    function automatic logic [2:0] mode_code(input mode_t m);
        logic [2:0] c;
        case (m)
            MODE_IDLE:  c = MODE_CODE_IDLE;
            MODE_EXIT:  c = MODE_CODE_EXIT;
            MODE_RED:   c = MODE_CODE_RED;
            MODE_AMBER: c = MODE_CODE_AMBER;
            MODE_GREEN: c = MODE_CODE_GREEN;
            default:    c = MODE_CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: sv/tlmsf_timer.sv
// Countdown timer with a sticky expired flag.
`timescale 1ns / 1ps
`default_nettype none
module tlmsf_timer
    import tlmsf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tmr_ctl_t              ctl,
    input  wire logic [TIMER_BITS-1:0] load_value,
    output logic                       expired
);

    logic [TIMER_BITS-1:0] count_reg, count_next, count_dec;
    logic                  flag_reg, flag_next, flag_dec;

    // Count down first; a timer at zero stays put
    always_comb
    begin
        count_dec = count_reg;
        flag_dec  = flag_reg;
        if (count_reg != '0)
        begin
            count_dec = count_reg - TIMER_BITS'(1);
            if (count_reg == TIMER_BITS'(1))
            begin
                flag_dec = 1'b1;
            end
        end
    end

    assign expired = flag_dec;

    always_comb
    begin
        count_next = count_reg;
        flag_next  = flag_reg;
        if (ctl.tick)
        begin
            if (ctl.load)
            begin
                count_next = load_value;
                flag_next  = 1'b0;
            end
            else
            begin
                count_next = count_dec;
                flag_next  = flag_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            flag_reg  <= flag_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/tlmsf_ctrl.sv
// Mode logic, blink phase and the committed, saved and trial duration sets.
`timescale 1ns / 1ps
`default_nettype none
module tlmsf_ctrl
    import tlmsf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  fire,
    input  wire in_item_t              item,
    input  wire logic                  blink_exp,
    input  wire logic                  idle_exp,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    output tmr_load_t                  tmr_load,
    output result_t                    res
);

    mode_t            mode_reg, mode_next;
    logic             phase_reg, phase_next;
    logic [DUR_W-1:0] com_reg [3];
    logic [DUR_W-1:0] sav_reg [3];
    logic [DUR_W-1:0] tri_reg [3];
    logic [DUR_W-1:0] com_next [3];
    logic [DUR_W-1:0] sav_next [3];
    logic [DUR_W-1:0] tri_next [3];

    logic             mode_p, up_any, shown_set, ret, bad_set;
    logic [2:0]       lamp;
    logic [DUR_W-1:0] shown;

    assign mode_p  = item.mode_short | item.mode_long;
    assign up_any  = item.up_short | item.up_long;
    assign bad_set = {1'b0, com_reg[COL_RED]} <
                     ({1'b0, com_reg[COL_AMBER]} + {1'b0, com_reg[COL_GREEN]});

    always_comb
    begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        com_next   = com_reg;
        sav_next   = sav_reg;
        tri_next   = tri_reg;
        tmr_load   = '0;
        lamp       = LAMP_UNCHANGED;
        ret        = 1'b0;
        shown      = '0;
        shown_set  = 1'b0;
        case (mode_reg)
            MODE_IDLE:
            begin
                if (item.enter_manual)
                begin
                    mode_next  = MODE_RED;
                    tmr_load   = '{blink_load: 1'b1, idle_load: 1'b1};
                    phase_next = 1'b0;
                end
            end
            MODE_EXIT:
            begin
                ret                 = 1'b1;
                tri_next[COL_AMBER] = com_reg[COL_AMBER];
                shown               = com_reg[COL_RED];
                shown_set           = 1'b1;
                mode_next           = MODE_IDLE;
            end
            MODE_RED:
            begin
                if (idle_exp)
                begin
                    mode_next = MODE_EXIT;
                    shown     = com_reg[COL_RED];
                    shown_set = 1'b1;
                end
                lamp = phase_reg ? LAMP_OFF : LAMP_RED;
                if (up_any)
                begin
                    tmr_load.idle_load = 1'b1;
                    tri_next[COL_RED]  = bump_duration(tri_next[COL_RED]);
                    shown              = tri_next[COL_RED];
                    shown_set          = 1'b1;
                end
                if (item.set_short)
                begin
                    tmr_load.idle_load = 1'b1;
                    com_next[COL_RED]  = tri_next[COL_RED];
                    shown              = com_next[COL_RED];
                    shown_set          = 1'b1;
                end
                if (mode_p)
                begin
                    mode_next  = MODE_AMBER;
                    tmr_load   = '{blink_load: 1'b1, idle_load: 1'b1};
                    phase_next = 1'b0;
                    shown      = tri_next[COL_AMBER];
                    shown_set  = 1'b1;
                end
                // A mode press restarts the blink timer and drops a pending expiry
                if (blink_exp && !mode_p)
                begin
                    tmr_load.blink_load = 1'b1;
                    phase_next          = ~phase_next;
                end
            end
            MODE_AMBER:
            begin
                if (idle_exp)
                begin
                    mode_next = MODE_EXIT;
                end
                lamp = phase_reg ? LAMP_OFF : LAMP_AMBER;
                if (mode_p)
                begin
                    mode_next  = MODE_GREEN;
                    tmr_load   = '{blink_load: 1'b1, idle_load: 1'b1};
                    phase_next = 1'b0;
                    shown      = tri_next[COL_GREEN];
                    shown_set  = 1'b1;
                end
                if (blink_exp && !mode_p)
                begin
                    tmr_load.blink_load = 1'b1;
                    phase_next          = ~phase_next;
                end
                if (up_any)
                begin
                    tmr_load.idle_load  = 1'b1;
                    tri_next[COL_AMBER] = bump_duration(tri_next[COL_AMBER]);
                    shown               = tri_next[COL_AMBER];
                    shown_set           = 1'b1;
                end
                if (item.set_short)
                begin
                    tmr_load.idle_load  = 1'b1;
                    com_next[COL_AMBER] = tri_next[COL_AMBER];
                    shown               = com_next[COL_AMBER];
                    shown_set           = 1'b1;
                end
            end
            MODE_GREEN:
            begin
                if (idle_exp)
                begin
                    mode_next = MODE_EXIT;
                end
                if (mode_p)
                begin
                    tmr_load.idle_load = 1'b1;
                    mode_next          = MODE_EXIT;
                    // Check the set: restore the saved one if red is too short
                    for (int i = 0; i < 3; i++)
                    begin
                        if (bad_set)
                        begin
                            com_next[i] = sav_reg[i];
                        end
                        else
                        begin
                            sav_next[i] = com_reg[i];
                        end
                        tri_next[i] = com_next[i];
                    end
                    shown     = com_next[COL_RED];
                    shown_set = 1'b1;
                end
                lamp = phase_reg ? LAMP_OFF : LAMP_GREEN;
                if (blink_exp)
                begin
                    tmr_load.blink_load = 1'b1;
                    phase_next          = ~phase_next;
                end
                // Each of the two up events adds one in green mode
                if (item.up_short)
                begin
                    tmr_load.idle_load  = 1'b1;
                    tri_next[COL_GREEN] = bump_duration(tri_next[COL_GREEN]);
                    shown               = tri_next[COL_GREEN];
                    shown_set           = 1'b1;
                end
                if (item.up_long)
                begin
                    tmr_load.idle_load  = 1'b1;
                    tri_next[COL_GREEN] = bump_duration(tri_next[COL_GREEN]);
                    shown               = tri_next[COL_GREEN];
                    shown_set           = 1'b1;
                end
                if (item.set_short)
                begin
                    tmr_load.idle_load  = 1'b1;
                    com_next[COL_GREEN] = tri_next[COL_GREEN];
                    shown               = com_next[COL_GREEN];
                    shown_set           = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (!shown_set)
        begin
            case (mode_next)
                MODE_RED:   shown = tri_next[COL_RED];
                MODE_AMBER: shown = tri_next[COL_AMBER];
                MODE_GREEN: shown = tri_next[COL_GREEN];
                default:    shown = com_next[COL_RED];
            endcase
        end
    end

    always_comb
    begin
        res.mode_now       = mode_code(mode_next);
        res.lamp_drive     = lamp;
        res.shown_duration = shown;
        res.red_duration   = com_next[COL_RED];
        res.amber_duration = com_next[COL_AMBER];
        res.green_duration = com_next[COL_GREEN];
        res.return_to_auto = ret;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            phase_reg <= 1'b0;
            com_reg   <= '{INIT_RED_RST, INIT_AMBER_RST, INIT_GREEN_RST};
            sav_reg   <= '{INIT_RED_RST, INIT_AMBER_RST, INIT_GREEN_RST};
            tri_reg   <= '{INIT_RED_RST, INIT_AMBER_RST, INIT_GREEN_RST};
        end
        else
        begin
            if (fire)
            begin
                mode_reg  <= mode_next;
                phase_reg <= phase_next;
                com_reg   <= com_next;
                sav_reg   <= sav_next;
                tri_reg   <= tri_next;
            end
            // Writing an initial duration loads all three sets of that colour
            if (wr_en)
            begin
                case (wr_index)
                    CFG_INIT_RED:
                    begin
                        com_reg[COL_RED] <= wr_data[DUR_W-1:0];
                        sav_reg[COL_RED] <= wr_data[DUR_W-1:0];
                        tri_reg[COL_RED] <= wr_data[DUR_W-1:0];
                    end
                    CFG_INIT_AMBER:
                    begin
                        com_reg[COL_AMBER] <= wr_data[DUR_W-1:0];
                        sav_reg[COL_AMBER] <= wr_data[DUR_W-1:0];
                        tri_reg[COL_AMBER] <= wr_data[DUR_W-1:0];
                    end
                    CFG_INIT_GREEN:
                    begin
                        com_reg[COL_GREEN] <= wr_data[DUR_W-1:0];
                        sav_reg[COL_GREEN] <= wr_data[DUR_W-1:0];
                        tri_reg[COL_GREEN] <= wr_data[DUR_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire

FILE: sv/traffic_light_manual_setup_fsm.sv
// Top level: input register, timers, mode logic and result register.
// A tick goes from the input register through the mode logic into the result register.
// Throughput: one tick per clock cycle, set by the single pass through the mode logic,
// while results are taken; while one waits, the input stage takes a new tick only if empty.
// Reset (rst_n low, asynchronous) empties both stages, puts the mode in automatic idle,
// stops both timers and loads durations red 5, amber 2, green 3 and the default timer settings.
`timescale 1ns / 1ps
`default_nettype none
module traffic_light_manual_setup_fsm
    import tlmsf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire in_item_t              item,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output result_t                    result,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data
);

    // Input stage
    logic      s1_valid_reg;
    in_item_t  s1_item_reg;

    // Result stage
    logic      result_valid_reg;
    result_t   result_reg;

    // Timer settings
    logic [TIMER_BITS-1:0] blink_half_reg;
    logic [TIMER_BITS-1:0] idle_timeout_reg;

    logic      out_ready;
    logic      s1_advance;
    logic      fire;
    logic      blink_exp, idle_exp;
    tmr_load_t tmr_load;
    tmr_ctl_t  blink_ctl, idle_ctl;
    result_t   res_comb;

    // The result register frees up when empty or when its transaction is taken
    assign out_ready  = !result_valid_reg || !result_stall;
    // Process the held tick whenever the result register can take it
    assign fire       = s1_valid_reg && out_ready;
    assign s1_advance = !s1_valid_reg || out_ready;
    assign item_stall = !s1_advance;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    // Hold the payload unless a new transaction is taken
    always_ff @(posedge clk)
    begin
        if (s1_advance && item_valid)
        begin
            s1_item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            result_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= res_comb;
        end
    end

    // Timer settings live here; the duration registers are loaded inside the mode logic
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_half_reg   <= BLINK_HALF_RST;
            idle_timeout_reg <= IDLE_TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_BLINK_HALF:   blink_half_reg   <= wr_data[TIMER_BITS-1:0];
                CFG_IDLE_TIMEOUT: idle_timeout_reg <= wr_data[TIMER_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Both timers advance once per processed tick, before the mode logic looks at them
    assign blink_ctl = '{tick: fire, load: tmr_load.blink_load};
    assign idle_ctl  = '{tick: fire, load: tmr_load.idle_load};

    tlmsf_timer u_blink_timer (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (blink_ctl),
        .load_value (blink_half_reg),
        .expired    (blink_exp)
    );

    tlmsf_timer u_idle_timer (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (idle_ctl),
        .load_value (idle_timeout_reg),
        .expired    (idle_exp)
    );

    tlmsf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (s1_item_reg),
        .blink_exp (blink_exp),
        .idle_exp  (idle_exp),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .tmr_load  (tmr_load),
        .res       (res_comb)
    );

    // A processed tick always lands in the result register
    a_fire_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> result_valid_reg)
        else $error("processed tick did not reach the result register");

    // Stall the input only while a tick is held that cannot move on
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (s1_valid_reg && result_valid_reg && result_stall))
        else $error("input stalled without a blocked held tick");

    // The return pulse comes with automatic idle and untouched lamps
    a_return_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.return_to_auto) |->
        (result_reg.mode_now == MODE_CODE_IDLE && result_reg.lamp_drive == LAMP_UNCHANGED))
        else $error("return pulse outside the exit tick");

endmodule
`default_nettype wire

FILE: test/tb.sv
// Testbench: self-checking stimulus and prediction for the manual set-up controller.
`timescale 1ns / 1ps
module tb;
    import tlmsf_pkg::*;

    // Quiet cycles (nothing accepted on either side) before the run is declared hung.
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASES        = 6;
    localparam int TICKS_PER_SET = 270;
    localparam int DIRECTED_ROWS = 24;

    // Button bits in the order of in_item_t, enter_manual on top
    localparam logic [5:0] B_NONE   = 6'b000000;
    localparam logic [5:0] B_ENTER  = 6'b100000;
    localparam logic [5:0] B_MODE_S = 6'b010000;
    localparam logic [5:0] B_MODE_L = 6'b001000;
    localparam logic [5:0] B_UP_S   = 6'b000100;
    localparam logic [5:0] B_UP_L   = 6'b000010;
    localparam logic [5:0] B_SET    = 6'b000001;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    in_item_t              item = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;
    logic                  wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data = '0;

    traffic_light_manual_setup_fsm dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Mirror of the controller: configuration, timers, modes and durations
    // ------------------------------------------------------------------
    logic [TIMER_BITS-1:0] blink_len;
    logic [TIMER_BITS-1:0] idle_len;
    logic [2:0]            cur_mode;
    logic                  blink_dark;    // high while the blinking colour is off
    logic [TIMER_BITS-1:0] blink_left;
    logic                  blink_over;
    logic [TIMER_BITS-1:0] idle_left;
    logic                  idle_over;
    logic [DUR_W-1:0]      committed [3];
    logic [DUR_W-1:0]      saved [3];
    logic [DUR_W-1:0]      trial [3];

    // Results that every transaction must show, oldest first
    result_t pending_results [$];
    int      mismatches = 0;
    logic    calm = 1'b0;       // high: neither side idles nor stalls

    typedef struct {
        logic [TIMER_BITS-1:0] blink;
        logic [TIMER_BITS-1:0] idle;
        logic [DUR_W-1:0]      red;
        logic [DUR_W-1:0]      amber;
        logic [DUR_W-1:0]      green;
    } setup_t;

    // Fixed settings for the first phases; the later ones are drawn at random.
    // Reds of 99 and greens of 99 make the up button wrap early; the second row
    // holds the slowest timers and a red that starts far short of green plus amber.
    setup_t plan [4] = '{
        '{16'd1,     16'd3,     7'd99, 7'd1,  7'd99},
        '{16'd65535, 16'd65535, 7'd1,  7'd99, 7'd1},
        '{16'd2,     16'd1,     7'd50, 7'd10, 7'd20},
        '{16'd7,     16'd25,    7'd98, 7'd98, 7'd1}
    };

    typedef struct {
        logic [5:0] stim;
        bit         typed;      // want holds the expected result, else predict it
        result_t    want;
    } step_row_t;

    // Walk through every mode with the reset durations 5 / 2 / 3.
    step_row_t walk [DIRECTED_ROWS] = '{
        // idle: quiet tick, then every button but enter is dropped
        '{B_NONE, 1'b1, '{MODE_CODE_IDLE, LAMP_UNCHANGED, 7'd5, 7'd5, 7'd2, 7'd3, 1'b0}},
        '{B_MODE_S | B_MODE_L | B_UP_S | B_UP_L | B_SET, 1'b1,
          '{MODE_CODE_IDLE, LAMP_UNCHANGED, 7'd5, 7'd5, 7'd2, 7'd3, 1'b0}},
        '{B_ENTER, 1'b1, '{MODE_CODE_RED, LAMP_UNCHANGED, 7'd5, 7'd5, 7'd2, 7'd3, 1'b0}},
        // red: enter is ignored, both up buttons together add only one
        '{B_ENTER, 1'b1, '{MODE_CODE_RED, LAMP_RED, 7'd5, 7'd5, 7'd2, 7'd3, 1'b0}},
        '{B_UP_S, 1'b1, '{MODE_CODE_RED, LAMP_RED, 7'd6, 7'd5, 7'd2, 7'd3, 1'b0}},
        '{B_UP_S | B_UP_L, 1'b1, '{MODE_CODE_RED, LAMP_RED, 7'd7, 7'd5, 7'd2, 7'd3, 1'b0}},
        '{B_SET, 1'b1, '{MODE_CODE_RED, LAMP_RED, 7'd7, 7'd7, 7'd2, 7'd3, 1'b0}},
        '{B_UP_L | B_SET, 1'b1, '{MODE_CODE_RED, LAMP_RED, 7'd8, 7'd8, 7'd2, 7'd3, 1'b0}},
        '{B_MODE_L, 1'b1, '{MODE_CODE_AMBER, LAMP_RED, 7'd2, 7'd8, 7'd2, 7'd3, 1'b0}},
        // amber: the mode press acts before the up press in the same tick
        '{B_UP_S, 1'b0, '0},
        '{B_SET, 1'b1, '{MODE_CODE_AMBER, LAMP_AMBER, 7'd3, 7'd8, 7'd3, 7'd3, 1'b0}},
        '{B_MODE_S | B_UP_S, 1'b0, '0},
        // green: short and long up presses each add one
        '{B_UP_S | B_UP_L, 1'b0, '0},
        '{B_SET, 1'b1, '{MODE_CODE_GREEN, LAMP_GREEN, 7'd5, 7'd8, 7'd3, 7'd5, 1'b0}},
        // exit press with a valid set (red equal to green plus amber): save it
        '{B_MODE_S, 1'b1, '{MODE_CODE_EXIT, LAMP_GREEN, 7'd8, 7'd8, 7'd3, 7'd5, 1'b0}},
        '{B_NONE, 1'b1, '{MODE_CODE_IDLE, LAMP_UNCHANGED, 7'd8, 7'd8, 7'd3, 7'd5, 1'b1}},
        '{B_ENTER | B_UP_S, 1'b1,
          '{MODE_CODE_RED, LAMP_UNCHANGED, 7'd8, 7'd8, 7'd3, 7'd5, 1'b0}},
        '{B_MODE_S, 1'b1, '{MODE_CODE_AMBER, LAMP_RED, 7'd3, 7'd8, 7'd3, 7'd5, 1'b0}},
        '{B_MODE_S, 1'b1, '{MODE_CODE_GREEN, LAMP_AMBER, 7'd5, 7'd8, 7'd3, 7'd5, 1'b0}},
        // commit a green too long for red, then exit: restore the saved set,
        // while the up press of the exit tick still bumps trial green
        '{B_UP_S, 1'b0, '0},
        '{B_SET, 1'b0, '0},
        '{B_MODE_L | B_UP_L, 1'b0, '0},
        // exit tick drops every button
        '{B_SET | B_UP_S | B_MODE_S, 1'b0, '0},
        '{B_NONE, 1'b0, '0}
    };

    function automatic logic [DUR_W-1:0] raise_duration(input logic [DUR_W-1:0] d);
        return (int'(d) >= DURATION_MAX) ? DUR_W'(1) : d + DUR_W'(1);
    endfunction

    task automatic restart_blink();
        blink_left = blink_len;
        blink_over = 1'b0;
    endtask

    task automatic restart_idle();
        idle_left = idle_len;
        idle_over = 1'b0;
    endtask

    task automatic load_colour(input int c, input logic [DUR_W-1:0] d);
        committed[c] = d;
        saved[c]     = d;
        trial[c]     = d;
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_BLINK_HALF:   blink_len = d;
            CFG_IDLE_TIMEOUT: idle_len = d;
            CFG_INIT_RED:     load_colour(COL_RED, d[DUR_W-1:0]);
            CFG_INIT_AMBER:   load_colour(COL_AMBER, d[DUR_W-1:0]);
            CFG_INIT_GREEN:   load_colour(COL_GREEN, d[DUR_W-1:0]);
            default:          ;
        endcase
    endtask

    // One timer tick: count both timers down, then run the mode logic in the
    // order the controller applies its actions; shown follows the last one.
    task automatic advance_setup(input in_item_t t, output result_t r);
        logic             mode_hit;
        logic             up_hit;
        logic             shown_ok;
        logic             ret;
        logic [2:0]       lamp;
        logic [DUR_W-1:0] shown;
        logic             bad_set;
        mode_hit = t.mode_short | t.mode_long;
        up_hit   = t.up_short | t.up_long;
        shown_ok = 1'b0;
        ret      = 1'b0;
        lamp     = LAMP_UNCHANGED;
        shown    = '0;

        if (blink_left != 0)
        begin
            blink_left--;
            if (blink_left == 0)
                blink_over = 1'b1;
        end
        if (idle_left != 0)
        begin
            idle_left--;
            if (idle_left == 0)
                idle_over = 1'b1;
        end

        case (cur_mode)
            MODE_CODE_IDLE:
            begin
                if (t.enter_manual)
                begin
                    cur_mode = MODE_CODE_RED;
                    restart_blink();
                    restart_idle();
                    blink_dark = 1'b0;
                end
            end
            MODE_CODE_EXIT:
            begin
                ret = 1'b1;
                trial[COL_AMBER] = committed[COL_AMBER];
                shown = committed[COL_RED];
                shown_ok = 1'b1;
                cur_mode = MODE_CODE_IDLE;
            end
            MODE_CODE_RED:
            begin
                if (idle_over)
                begin
                    cur_mode = MODE_CODE_EXIT;
                    shown = committed[COL_RED];
                    shown_ok = 1'b1;
                end
                lamp = blink_dark ? LAMP_OFF : LAMP_RED;
                if (up_hit)
                begin
                    restart_idle();
                    trial[COL_RED] = raise_duration(trial[COL_RED]);
                    shown = trial[COL_RED];
                    shown_ok = 1'b1;
                end
                if (t.set_short)
                begin
                    restart_idle();
                    committed[COL_RED] = trial[COL_RED];
                    shown = committed[COL_RED];
                    shown_ok = 1'b1;
                end
                if (mode_hit)
                begin
                    cur_mode = MODE_CODE_AMBER;
                    restart_blink();
                    restart_idle();
                    blink_dark = 1'b0;
                    shown = trial[COL_AMBER];
                    shown_ok = 1'b1;
                end
                if (blink_over)
                begin
                    restart_blink();
                    blink_dark = ~blink_dark;
                end
            end
            MODE_CODE_AMBER:
            begin
                if (idle_over)
                    cur_mode = MODE_CODE_EXIT;
                lamp = blink_dark ? LAMP_OFF : LAMP_AMBER;
                if (mode_hit)
                begin
                    restart_idle();
                    cur_mode = MODE_CODE_GREEN;
                    restart_blink();
                    blink_dark = 1'b0;
                    shown = trial[COL_GREEN];
                    shown_ok = 1'b1;
                end
                if (blink_over)
                begin
                    restart_blink();
                    blink_dark = ~blink_dark;
                end
                if (up_hit)
                begin
                    restart_idle();
                    trial[COL_AMBER] = raise_duration(trial[COL_AMBER]);
                    shown = trial[COL_AMBER];
                    shown_ok = 1'b1;
                end
                if (t.set_short)
                begin
                    restart_idle();
                    committed[COL_AMBER] = trial[COL_AMBER];
                    shown = committed[COL_AMBER];
                    shown_ok = 1'b1;
                end
            end
            MODE_CODE_GREEN:
            begin
                if (idle_over)
                    cur_mode = MODE_CODE_EXIT;
                if (mode_hit)
                begin
                    restart_idle();
                    cur_mode = MODE_CODE_EXIT;
                    // Red must cover green plus amber; sum in full width
                    bad_set = int'(committed[COL_RED]) <
                              int'(committed[COL_AMBER]) + int'(committed[COL_GREEN]);
                    for (int c = 0; c < 3; c++)
                    begin
                        if (bad_set)
                            committed[c] = saved[c];
                        else
                            saved[c] = committed[c];
                        trial[c] = committed[c];
                    end
                    shown = committed[COL_RED];
                    shown_ok = 1'b1;
                end
                lamp = blink_dark ? LAMP_OFF : LAMP_GREEN;
                if (blink_over)
                begin
                    blink_dark = ~blink_dark;
                    restart_blink();
                end
                if (t.up_short)
                begin
                    restart_idle();
                    trial[COL_GREEN] = raise_duration(trial[COL_GREEN]);
                    shown = trial[COL_GREEN];
                    shown_ok = 1'b1;
                end
                if (t.up_long)
                begin
                    restart_idle();
                    trial[COL_GREEN] = raise_duration(trial[COL_GREEN]);
                    shown = trial[COL_GREEN];
                    shown_ok = 1'b1;
                end
                if (t.set_short)
                begin
                    restart_idle();
                    committed[COL_GREEN] = trial[COL_GREEN];
                    shown = committed[COL_GREEN];
                    shown_ok = 1'b1;
                end
            end
            default: ;
        endcase

        // Nothing displayed this tick: show the trial of the colour being set
        if (!shown_ok)
        begin
            if (cur_mode == MODE_CODE_RED)
                shown = trial[COL_RED];
            else if (cur_mode == MODE_CODE_AMBER)
                shown = trial[COL_AMBER];
            else if (cur_mode == MODE_CODE_GREEN)
                shown = trial[COL_GREEN];
            else
                shown = committed[COL_RED];
        end

        r.mode_now       = cur_mode;
        r.lamp_drive     = lamp;
        r.shown_duration = shown;
        r.red_duration   = committed[COL_RED];
        r.amber_duration = committed[COL_AMBER];
        r.green_duration = committed[COL_GREEN];
        r.return_to_auto = ret;
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic log_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    result_t oldest;

    // Take each result transaction and compare it with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
                log_mismatch("result with no transaction pending", result.mode_now, 0);
            else
            begin
                oldest = pending_results.pop_front();
                if (result.mode_now !== oldest.mode_now)
                    log_mismatch("mode_now", result.mode_now, oldest.mode_now);
                if (result.lamp_drive !== oldest.lamp_drive)
                    log_mismatch("lamp_drive", result.lamp_drive, oldest.lamp_drive);
                if (result.shown_duration !== oldest.shown_duration)
                    log_mismatch("shown_duration", result.shown_duration,
                                 oldest.shown_duration);
                if (result.red_duration !== oldest.red_duration)
                    log_mismatch("red_duration", result.red_duration, oldest.red_duration);
                if (result.amber_duration !== oldest.amber_duration)
                    log_mismatch("amber_duration", result.amber_duration,
                                 oldest.amber_duration);
                if (result.green_duration !== oldest.green_duration)
                    log_mismatch("green_duration", result.green_duration,
                                 oldest.green_duration);
                if (result.return_to_auto !== oldest.return_to_auto)
                    log_mismatch("return_to_auto", result.return_to_auto,
                                 oldest.return_to_auto);
            end
        end
    end

    // Stall the result side about a quarter of the time, except in a calm stretch.
    always @(posedge clk)
    begin
        result_stall <= !calm && ($urandom_range(0, 99) < 24);
    end

    // Watchdog: end the run when nothing moves on either side for too long.
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("FAIL traffic_light_manual_setup_fsm");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offer one tick, hold it until taken, then predict its result.
    task automatic send_tick(input in_item_t t, input bit typed, input result_t want);
        result_t predicted;
        while (!calm && $urandom_range(0, 99) < 24)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= t;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        advance_setup(t, predicted);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Drop valid and hold off until every expected result has come back.
    task automatic drain_results();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= d;
        @(posedge clk);
        apply_reg(idx, d);
    endtask

    // Write all five registers back to back; the block is empty here.
    task automatic write_setup(input setup_t s);
        put_reg(CFG_BLINK_HALF, s.blink);
        put_reg(CFG_IDLE_TIMEOUT, s.idle);
        put_reg(CFG_INIT_RED, CFG_DATA_W'(s.red));
        put_reg(CFG_INIT_AMBER, CFG_DATA_W'(s.amber));
        put_reg(CFG_INIT_GREEN, CFG_DATA_W'(s.green));
        wr_en <= 1'b0;
    endtask

    // Pick the next tick from the current mode so that sessions run deep:
    // enter from idle, then mostly up, set and mode presses. A slice is noise.
    function automatic in_item_t pick_tick();
        in_item_t t;
        t = '0;
        if ($urandom_range(0, 99) < 12)
            t = in_item_t'(6'($urandom_range(0, 63)));
        else if (cur_mode == MODE_CODE_IDLE)
            t.enter_manual = ($urandom_range(0, 99) < 60);
        else if (cur_mode != MODE_CODE_EXIT)
        begin
            t.up_short   = ($urandom_range(0, 99) < 30);
            t.up_long    = ($urandom_range(0, 99) < 12);
            t.set_short  = ($urandom_range(0, 99) < 12);
            t.mode_short = ($urandom_range(0, 99) < 8);
            t.mode_long  = ($urandom_range(0, 99) < 4);
        end
        return t;
    endfunction

    initial
    begin
        setup_t   s;
        in_item_t t;
        int       counted;
        int       pause_at;
        bit       useful;

        blink_len  = BLINK_HALF_RST;
        idle_len   = IDLE_TIMEOUT_RST;
        cur_mode   = MODE_CODE_IDLE;
        blink_dark = 1'b0;
        blink_left = '0;
        blink_over = 1'b0;
        idle_left  = '0;
        idle_over  = 1'b0;
        load_colour(COL_RED, INIT_RED_RST);
        load_colour(COL_AMBER, INIT_AMBER_RST);
        load_colour(COL_GREEN, INIT_GREEN_RST);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk with the reset settings
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_tick(in_item_t'(walk[i].stim), walk[i].typed, walk[i].want);
        drain_results();

        // Random phases, each under its own settings
        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 4)
                s = plan[p];
            else
            begin
                s.blink = TIMER_BITS'($urandom_range(1, 6));
                s.idle  = TIMER_BITS'($urandom_range(1, 30));
                s.red   = DUR_W'($urandom_range(1, 99));
                s.amber = DUR_W'($urandom_range(1, 99));
                s.green = DUR_W'($urandom_range(1, 99));
            end
            write_setup(s);
            calm = (p == 1);
            pause_at = $urandom_range(60, TICKS_PER_SET - 60);
            counted = 0;
            while (counted < TICKS_PER_SET)
            begin
                t = pick_tick();
                // Ticks in idle without enter are simply dropped; skip them in the count
                useful = (cur_mode != MODE_CODE_IDLE) || t.enter_manual;
                send_tick(t, 1'b0, '0);
                if (useful)
                    counted++;
                if (useful && counted == pause_at)
                    drain_results();
            end
            drain_results();
        end
        calm = 1'b0;

        // Let any stray result surface before the verdict
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS traffic_light_manual_setup_fsm");
        else
            $display("FAIL traffic_light_manual_setup_fsm");
        $finish;
    end

endmodule
